>>> hdl/btnpk_pkg.sv
// Shared types and constants for the bounded top-N priority keeper.
// No dependencies; imported by btnpk_cell and bounded_top_n_priority_keeper.
`default_nettype none

package btnpk_pkg;

  localparam int KEY_W        = 32;
  localparam int HANDLE_W     = 16;
  localparam int COUNT_OUT_W  = 7;
  localparam int CAPACITY_DEF = 64;

  // One stored entry: handle with its priority key.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } slot_t;

  // Chain-wide control broadcast to every cell.
  typedef struct packed {
    logic ld;    // update the chain this cycle
    logic full;  // evict the lowest entry while inserting
  } chain_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/bounded_top_n_priority_keeper.sv
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one insert per cycle while the result side takes every result;
// every cell compares against the broadcast newcomer in the same cycle.
// Reset (rst_n low, synchronous) clears the fill count and the output valid;
// stored entries are not cleared and are never read until written.
// Top level of the sorted cell chain; depends on btnpk_pkg and btnpk_cell.
`default_nettype none

module bounded_top_n_priority_keeper
  import btnpk_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [HANDLE_W-1:0]    in_entry_handle,
  input  wire logic [KEY_W-1:0]       in_priority_key,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_dropped_valid,
  output logic [HANDLE_W-1:0]         out_dropped_handle,
  output logic [KEY_W-1:0]            out_dropped_key,
  output logic [COUNT_OUT_W-1:0]      out_stored_count,
  output logic [HANDLE_W-1:0]         out_min_handle,
  output logic [KEY_W-1:0]            out_min_key
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  logic             drop_valid_r;
  slot_t            drop_r;
  slot_t            min_r;
  logic [COUNT_OUT_W-1:0] count_out_r;

  slot_t       new_slot;
  slot_t       cell_q   [CAPACITY];
  slot_t       cell_nxt [CAPACITY];
  logic        cell_gt  [CAPACITY];
  chain_ctrl_t ctrl;
  logic        accept;
  logic        full;
  logic        drop_new;

  assign new_slot = '{handle: in_entry_handle, key: in_priority_key};

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  // Full store and newcomer strictly below the minimum: drop the newcomer.
  assign drop_new = full && (in_priority_key < cell_q[0].key);

  assign ctrl.ld   = accept && !drop_new;
  assign ctrl.full = full;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      slot_t lo_s, hi_s;
      logic  lo_g, hi_g;
      if (gi == 0) begin : g_bot
        assign lo_s = '0;
        assign lo_g = 1'b0;
      end else begin : g_mid_lo
        assign lo_s = cell_q[gi-1];
        assign lo_g = cell_gt[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_top
        assign hi_s = '0;
        assign hi_g = 1'b1;
      end else begin : g_mid_hi
        assign hi_s = cell_q[gi+1];
        assign hi_g = cell_gt[gi+1];
      end

      btnpk_cell #(
        .CELL_IDX (gi),
        .CNT_W    (CNT_W)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .cnt      (cnt_r),
        .new_slot (new_slot),
        .lo_slot  (lo_s),
        .hi_slot  (hi_s),
        .lo_gt    (lo_g),
        .hi_gt    (hi_g),
        .gt       (cell_gt[gi]),
        .slot_q   (cell_q[gi]),
        .slot_nxt (cell_nxt[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !full) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      drop_valid_r <= full;
      if (!full) begin
        drop_r <= '0;
      end else if (drop_new) begin
        drop_r <= new_slot;
      end else begin
        drop_r <= cell_q[0];
      end
      min_r       <= cell_nxt[0];
      count_out_r <= COUNT_OUT_W'(cnt_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dropped_valid  = drop_valid_r;
  assign out_dropped_handle = drop_r.handle;
  assign out_dropped_key    = drop_r.key;
  assign out_stored_count   = count_out_r;
  assign out_min_handle     = min_r.handle;
  assign out_min_key        = min_r.key;

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full) |=> (cnt_r == CNT_W'(CAPACITY)))
    else $error("fill count changed on a full insert");

  a_dropped_not_above_min : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && drop_valid_r) |-> (drop_r.key <= min_r.key))
    else $error("dropped entry above the kept minimum");

  a_chain_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> (cell_q[0].key <= cell_q[1].key))
    else $error("bottom of chain out of order");

endmodule

`default_nettype wire

>>> hdl/btnpk_cell.sv
// One cell of the sorted chain: holds a single entry and picks its next value
// from itself, the incoming entry or a neighbour. Depends on btnpk_pkg.
`default_nettype none

module btnpk_cell
  import btnpk_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 7
) (
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0] cnt,
  input  wire slot_t       new_slot,
  input  wire slot_t       lo_slot,
  input  wire slot_t       hi_slot,
  input  wire logic        lo_gt,
  input  wire logic        hi_gt,
  output logic             gt,
  output slot_t            slot_q,
  output slot_t            slot_nxt
);

  slot_t slot_r;

  // Empty cells count as above the newcomer; ties stay below it.
  assign gt = (CNT_W'(CELL_IDX) >= cnt) || (slot_r.key > new_slot.key);

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.ld) begin
      if (ctrl.full) begin
        // Shift down towards the evicted bottom up to the insertion point.
        if (!hi_gt) begin
          slot_nxt = hi_slot;
        end else if (!gt) begin
          slot_nxt = new_slot;
        end
      end else begin
        // Shift up above the insertion point.
        if (gt) begin
          if (!lo_gt) begin
            slot_nxt = new_slot;
          end else begin
            slot_nxt = lo_slot;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule

`default_nettype wire
